FILE: design/status_frame_transmitter_defines.svh
`ifndef STATUS_FRAME_TRANSMITTER_DEFINES_SVH
`define STATUS_FRAME_TRANSMITTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Check that cons holds in the cycle after ante.
`define SFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: design/sft_pkg.sv
`default_nettype none

package sft_pkg;

  typedef struct packed {
    logic [15:0] speed;
    logic        left_turn;
    logic        right_turn;
  } sft_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } sft_out_t;

  localparam logic [7:0]  FRAME_MARK  = 8'h5E;
  localparam logic [7:0]  ESCAPE_MARK = 8'h5F;
  localparam logic [7:0]  ESC_HEAD    = 8'h01;
  localparam logic [7:0]  ESC_ESCAPE  = 8'h02;
  localparam logic [7:0]  CMD_STATUS  = 8'h40;
  localparam logic [7:0]  LEN_LOW     = 8'h04;
  localparam logic [7:0]  ZERO_BYTE   = 8'h00;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // Byte position within a frame; idle when no frame is in flight.
  typedef enum logic [3:0] {
    POS_IDLE,
    POS_HEAD,
    POS_CNT,
    POS_ESC,
    POS_CMD,
    POS_LEN_LO,
    POS_LEN_HI,
    POS_SPD_LO,
    POS_SPD_HI,
    POS_FLAGS,
    POS_PAD,
    POS_CRC_LO,
    POS_CRC_HI,
    POS_TAIL
  } sft_pos_e;

  // Reflected CRC-16, one byte folded in.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/status_frame_transmitter.sv
// Channel | Dir | Handshake            | Word
// in      | in  | in_valid_i/in_stall_o | in_i  (speed, left_turn, right_turn)
// out     | out | out_valid_o/out_stall_i | out_o (out_byte, frame_end)
//
// A request yields 12 frame words, or 13 when the counter byte is escaped.
// One word leaves per cycle while the output is not stalled; the byte sequencer
// sets the rate, and the next request is taken as the tail word leaves.
// The CRC is folded in one byte per cycle as the body words go out unstalled.
// Reset clears the frame counter and the sequencer; the first frame carries 0x01.
// A stall on a full output register holds it and the sequencer in the same cycle.
`default_nettype none

module status_frame_transmitter import sft_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire sft_in_t  in_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sft_out_t      out_o
);

  logic     byte_valid;
  logic     byte_stall;
  sft_out_t byte_w;
  logic     out_valid_q;
  sft_out_t out_q;

  sft_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_stall_o  (in_stall_o),
    .req_i        (in_i),
    .byte_valid_o (byte_valid),
    .byte_stall_i (byte_stall),
    .byte_o       (byte_w)
  );

  // Load a new word whenever the register is empty or being drained.
  assign byte_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!byte_stall) begin
      out_valid_q <= byte_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!byte_stall && byte_valid) begin
      out_q <= byte_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

FILE: design/sft_framer.sv
`default_nettype none

`include "status_frame_transmitter_defines.svh"

module sft_framer import sft_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_stall_o,
  input  wire sft_in_t  req_i,
  output logic          byte_valid_o,
  input  wire logic     byte_stall_i,
  output sft_out_t      byte_o
);

  sft_pos_e    pos_q, pos_d;
  sft_in_t     req_q;
  logic [7:0]  cnt_q;
  logic [15:0] crc_q, crc_d;
  logic        byte_fire;
  logic        req_fire;
  logic        escaped;
  logic        crc_en;

  assign escaped      = (cnt_q == FRAME_MARK) || (cnt_q == ESCAPE_MARK);
  assign byte_valid_o = (pos_q != POS_IDLE);
  assign byte_fire    = byte_valid_o && !byte_stall_i;
  // Take a request while idle or while the tail word leaves.
  assign req_stall_o  = byte_valid_o && !(byte_fire && (pos_q == POS_TAIL));
  assign req_fire     = req_valid_i && !req_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_IDLE;
      cnt_q <= 8'h00;
    end else begin
      pos_q <= pos_d;
      if (req_fire) begin
        cnt_q <= cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i;
    end
    crc_q <= crc_d;
  end

  always_comb begin
    pos_d           = pos_q;
    crc_en          = 1'b0;
    byte_o.out_byte = ZERO_BYTE;
    byte_o.frame_end = 1'b0;
    unique case (pos_q)
      POS_IDLE: begin
      end
      POS_HEAD: begin
        byte_o.out_byte = FRAME_MARK;
        pos_d = POS_CNT;
      end
      POS_CNT: begin
        byte_o.out_byte = escaped ? ESCAPE_MARK : cnt_q;
        pos_d = escaped ? POS_ESC : POS_CMD;
      end
      POS_ESC: begin
        byte_o.out_byte = (cnt_q == FRAME_MARK) ? ESC_HEAD : ESC_ESCAPE;
        pos_d = POS_CMD;
      end
      POS_CMD: begin
        byte_o.out_byte = CMD_STATUS;
        crc_en = 1'b1;
        pos_d = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        byte_o.out_byte = LEN_LOW;
        crc_en = 1'b1;
        pos_d = POS_LEN_HI;
      end
      POS_LEN_HI: begin
        byte_o.out_byte = ZERO_BYTE;
        crc_en = 1'b1;
        pos_d = POS_SPD_LO;
      end
      POS_SPD_LO: begin
        byte_o.out_byte = req_q.speed[7:0];
        crc_en = 1'b1;
        pos_d = POS_SPD_HI;
      end
      POS_SPD_HI: begin
        byte_o.out_byte = req_q.speed[15:8];
        crc_en = 1'b1;
        pos_d = POS_FLAGS;
      end
      POS_FLAGS: begin
        byte_o.out_byte = {3'b000, req_q.right_turn, req_q.left_turn, 3'b000};
        crc_en = 1'b1;
        pos_d = POS_PAD;
      end
      POS_PAD: begin
        byte_o.out_byte = ZERO_BYTE;
        crc_en = 1'b1;
        pos_d = POS_CRC_LO;
      end
      POS_CRC_LO: begin
        byte_o.out_byte = crc_q[7:0];
        pos_d = POS_CRC_HI;
      end
      POS_CRC_HI: begin
        byte_o.out_byte = crc_q[15:8];
        pos_d = POS_TAIL;
      end
      POS_TAIL: begin
        byte_o.out_byte = FRAME_MARK;
        byte_o.frame_end = 1'b1;
        pos_d = POS_IDLE;
      end
      default: begin
        pos_d = POS_IDLE;
      end
    endcase

    // Hold position while the word is stalled.
    if (!byte_fire) begin
      pos_d = pos_q;
    end
    if (req_fire) begin
      pos_d = POS_HEAD;
    end

    crc_d = crc_q;
    if (req_fire) begin
      crc_d = CRC_INIT;
    end else if (byte_fire && crc_en) begin
      crc_d = crc_byte(crc_q, byte_o.out_byte);
    end
  end

  `SFT_ASSERT_NEXT(a_req_starts_frame, clk_i, rst_ni, req_fire, pos_q == POS_HEAD)
  `SFT_ASSERT_NEXT(a_cnt_steps, clk_i, rst_ni, req_fire, cnt_q == 8'($past(cnt_q) + 8'd1))
  `SFT_ASSERT_NOW(a_esc_only_marks, clk_i, rst_ni, pos_q == POS_ESC, escaped)
  `SFT_ASSERT_NOW(a_crc_seeded, clk_i, rst_ni, pos_q == POS_CMD, crc_q == CRC_INIT)

endmodule

`default_nettype wire
